@@ sv/triangle_mesh_edge_split_macros.svh @@
// Assertion macros for the triangle mesh edge split block.
// Used by the top level; depends on nothing else.
`ifndef TRIANGLE_MESH_EDGE_SPLIT_MACROS_SVH
`define TRIANGLE_MESH_EDGE_SPLIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TMES_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tmes: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TMES_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tmes: next-cycle check failed");

`endif

@@ sv/tmes_pkg.sv @@
// Shared types, codes and helpers for the triangle mesh edge split block.
// No dependencies; imported by the top level.
package tmes_pkg;

  localparam int MAX_VERTS = 4096;
  localparam int MAX_FACES = 4096;
  localparam int COORD_W   = 32;
  localparam int VIDX_W    = $clog2(MAX_VERTS);
  localparam int FIDX_W    = $clog2(MAX_FACES);
  localparam int NBR_W     = FIDX_W + 1;
  localparam int CNT_W     = VIDX_W + 1;
  localparam int WGT_W     = 17;
  localparam int VAL_W     = 32;

  localparam logic [NBR_W-1:0] NBR_NONE  = '1;
  localparam logic [WGT_W-1:0] WGT_ONE   = 17'd65536;
  localparam logic [WGT_W-1:0] WGT_RESET = 17'd39322;
  localparam logic [1:0]       CORNER_BAD = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_TWO_LAYER = 1'b0;
  localparam logic CFG_WEIGHT    = 1'b1;

  typedef enum logic [2:0] {
    REQ_WR_VERT   = 3'd0,
    REQ_WR_CORNER = 3'd1,
    REQ_SPLIT     = 3'd2,
    REQ_RD_VERT   = 3'd3,
    REQ_RD_CORNER = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BOUNDARY = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_RANGE    = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FAIL, ST_VWR, ST_VRD, ST_VOUT, ST_FRD, ST_FWR, ST_FOUT,
    SP_CHK0, SP_RDA, SP_CHK1, SP_RDB, SP_CHK2, SP_VRA, SP_VRB, SP_VRC,
    SP_MUL, SP_ADD, SP_VWR, SP_FRD, SP_FWR
  } st_t;

  // Face-table steps of a split, in the order they are applied.
  typedef enum logic [2:0] {
    OP_P12 = 3'd0,
    OP_P02 = 3'd1,
    OP_CPA = 3'd2,
    OP_CPB = 3'd3,
    OP_MDA = 3'd4,
    OP_MDB = 3'd5
  } fop_t;

  typedef logic [2:0][COORD_W-1:0] vrow_t;

  typedef struct packed {
    logic [2:0][VIDX_W-1:0] verts;
    logic [2:0][NBR_W-1:0]  nbrs;
    logic [2:0][1:0]        ncorn;
    logic [2:0][VAL_W-1:0]  pj;
    logic [2:0][VAL_W-1:0]  kappa;
  } face_row_t;

  function automatic logic [1:0] inc3(input logic [1:0] c);
    return (c == 2'd2) ? 2'd0 : c + 2'd1;
  endfunction

  function automatic logic [1:0] dec3(input logic [1:0] c);
    return (c == 2'd0) ? 2'd2 : c - 2'd1;
  endfunction

  // A neighbor reference names a face that exists.
  function automatic logic face_ok(input logic [NBR_W-1:0] n, input logic [CNT_W-1:0] cnt);
    return !n[NBR_W-1] && ({1'b0, n[FIDX_W-1:0]} < cnt);
  endfunction

endpackage

@@ sv/triangle_mesh_edge_split.sv @@
// Top level of the triangle mesh edge split block: request sequencer,
// vertex and face tables. Depends on tmes_pkg, tmes_ram and the macro header.
//
//  channel | handshake              | beat contents
//  --------+------------------------+--------------------------------------
//  request | start / busy           | in_req_type, in_item_index, ... fields
//  result  | out_valid (strobe)     | out_status, out_new_vertex, ... fields
//  config  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request is processed at a time; busy is high from acceptance until the
// result strobe. A split is the longest request, set by the single read and
// write port of the face table (a read and then a write per row update) and
// the serial interpolation of three coordinates per vertex; it takes longer
// in two-layer mode, where each read, vertex and face step is repeated for the second layer.
// Reset clears the control state, counts and configuration only; the tables need no clearing.
// The receiver cannot stall; each result is shown for exactly one cycle.
`include "triangle_mesh_edge_split_macros.svh"

module triangle_mesh_edge_split
  import tmes_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                in_req_type,
  input  logic [VIDX_W-1:0]         in_item_index,
  input  logic [1:0]                in_corner,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic signed [COORD_W-1:0] in_coord_z,
  input  logic [VIDX_W-1:0]         in_vertex_id,
  input  logic signed [NBR_W-1:0]   in_neighbor_face,
  input  logic [1:0]                in_neighbor_corner,
  input  logic [VAL_W-1:0]          in_pj_value,
  input  logic [VAL_W-1:0]          in_kappa_value,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [VIDX_W-1:0]         out_new_vertex,
  output logic [FIDX_W-1:0]         out_new_face,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic signed [COORD_W-1:0] out_z,
  output logic [VIDX_W-1:0]         out_vertex_id,
  output logic signed [NBR_W-1:0]   out_neighbor_face,
  output logic [1:0]                out_neighbor_corner,
  output logic [VAL_W-1:0]          out_pj,
  output logic [VAL_W-1:0]          out_kappa,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [WGT_W-1:0]          cfg_data
);

  localparam int PROD_W = COORD_W + 19;

  // Control state.
  st_t                 state_r, state_nxt;
  fop_t                op_r, op_nxt;
  logic                lsel_r, lsel_nxt;
  logic [1:0]          k_r, k_nxt;
  logic                two_layer_r, two_layer_nxt;
  logic [WGT_W-1:0]    weight_r, weight_nxt;
  logic [CNT_W-1:0]    vc_r, vc_nxt;
  logic [CNT_W-1:0]    fc_r, fc_nxt;

  // Latched request.
  logic [2:0]          req_r, req_nxt;
  logic [VIDX_W-1:0]   idx_r, idx_nxt;
  logic [1:0]          corner_r, corner_nxt;
  vrow_t               coord_r, coord_nxt;
  logic [VIDX_W-1:0]   vid_r, vid_nxt;
  logic [NBR_W-1:0]    nbr_r, nbr_nxt;
  logic [1:0]          ncorn_r, ncorn_nxt;
  logic [VAL_W-1:0]    pj_r, pj_nxt;
  logic [VAL_W-1:0]    kappa_r, kappa_nxt;

  // Split working set; the face, corner and vertex index arrays have one slot per layer.
  logic [1:0][NBR_W-1:0]  fb_r, fb_nxt;
  logic [1:0][NBR_W-1:0]  f02_r, f02_nxt;
  logic [1:0][NBR_W-1:0]  f12_r, f12_nxt;
  logic [1:0][1:0]        c02_r, c02_nxt;
  logic [1:0][1:0]        c12_r, c12_nxt;
  logic [1:0][VIDX_W-1:0] u0_r, u0_nxt;
  logic [1:0][VIDX_W-1:0] u1_r, u1_nxt;
  logic [1:0]             e1_r, e1_nxt;
  vrow_t                  va_r, va_nxt;
  vrow_t                  vb_r, vb_nxt;
  vrow_t                  nv_r, nv_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;

  // Result registers.
  logic                ov_r, ov_nxt;
  status_t             ostat_r, ostat_nxt;
  logic [VIDX_W-1:0]   onv_r, onv_nxt;
  logic [FIDX_W-1:0]   onf_r, onf_nxt;
  vrow_t               ocoord_r, ocoord_nxt;
  logic [VIDX_W-1:0]   ovid_r, ovid_nxt;
  logic [NBR_W-1:0]    onbr_r, onbr_nxt;
  logic [1:0]          oncorn_r, oncorn_nxt;
  logic [VAL_W-1:0]    opj_r, opj_nxt;
  logic [VAL_W-1:0]    okap_r, okap_nxt;

  // Memory ports.
  logic                vram_we;
  logic [VIDX_W-1:0]   vram_waddr, vram_raddr;
  vrow_t               vram_wdata, vram_rdata;
  logic                fram_we;
  logic [FIDX_W-1:0]   fram_waddr, fram_raddr;
  face_row_t           fram_wdata, fram_rdata;

  // Derived values for the split.
  logic [1:0]          e01, e02, e11, e12;
  logic [FIDX_W-1:0]   fa_l, fb_l, fx0_l, fx1_l, op_addr, op_waddr;
  logic [VIDX_W-1:0]   ux_l;
  logic                last_l, skip_op;
  logic [WGT_W-1:0]    w_cl;
  logic signed [COORD_W:0]  diff;
  logic signed [PROD_W-1:0] sum;
  logic                fin;
  status_t             fin_stat;
  logic                bad_l, full;

  tmes_ram #(.WIDTH($bits(vrow_t)), .DEPTH(MAX_VERTS)) u_vram (
    .clk  (clk),
    .we   (vram_we),
    .waddr(vram_waddr),
    .wdata(vram_wdata),
    .raddr(vram_raddr),
    .rdata(vram_rdata)
  );

  tmes_ram #(.WIDTH($bits(face_row_t)), .DEPTH(MAX_FACES)) u_fram (
    .clk  (clk),
    .we   (fram_we),
    .waddr(fram_waddr),
    .wdata(fram_wdata),
    .raddr(fram_raddr),
    .rdata(fram_rdata)
  );

  // Corner arithmetic and per-layer indexes.
  assign e01    = inc3(corner_r);
  assign e02    = dec3(corner_r);
  assign e11    = inc3(e1_r);
  assign e12    = dec3(e1_r);
  assign fa_l   = idx_r ^ FIDX_W'(lsel_r);
  assign fb_l   = fb_r[lsel_r][FIDX_W-1:0];
  assign ux_l   = vc_r[VIDX_W-1:0] + VIDX_W'(lsel_r);
  assign fx0_l  = fc_r[FIDX_W-1:0] + FIDX_W'(lsel_r);
  assign fx1_l  = fc_r[FIDX_W-1:0] + FIDX_W'(1) + FIDX_W'(two_layer_r) + FIDX_W'(lsel_r);
  assign last_l = !two_layer_r || lsel_r;
  assign w_cl   = (weight_r > WGT_ONE) ? WGT_ONE : weight_r;

  // Interpolation datapath: weight times difference, then offset and round.
  assign diff = $signed({va_r[k_r][COORD_W-1], va_r[k_r]})
              - $signed({vb_r[k_r][COORD_W-1], vb_r[k_r]});
  assign sum  = prod_r
              + $signed({{3{vb_r[k_r][COORD_W-1]}}, vb_r[k_r], 16'h0000})
              + $signed(PROD_W'(32768));

  // Face step addressing.
  always_comb begin
    unique case (op_r)
      OP_P12:         op_addr = f12_r[lsel_r][FIDX_W-1:0];
      OP_P02:         op_addr = f02_r[lsel_r][FIDX_W-1:0];
      OP_CPA, OP_MDA: op_addr = fa_l;
      OP_CPB, OP_MDB: op_addr = fb_l;
      default:        op_addr = fa_l;
    endcase
    case (op_r)
      OP_CPA:  op_waddr = fx0_l;
      OP_CPB:  op_waddr = fx1_l;
      default: op_waddr = op_addr;
    endcase
    skip_op = ((op_r == OP_P12) && (f12_r[lsel_r] == NBR_NONE))
           || ((op_r == OP_P02) && (f02_r[lsel_r] == NBR_NONE));
  end

  // Validity checks on the neighborhood and room for the new elements.
  always_comb begin
    bad_l = 1'b0;
    for (int l = 0; l < 2; l++) begin
      if (l == 0 || two_layer_r) begin
        if (f02_r[l] != NBR_NONE && (!face_ok(f02_r[l], fc_r) || c02_r[l] == CORNER_BAD))
          bad_l = 1'b1;
        if (f12_r[l] != NBR_NONE && (!face_ok(f12_r[l], fc_r) || c12_r[l] == CORNER_BAD))
          bad_l = 1'b1;
        if ({1'b0, u1_r[l]} >= vc_r || {1'b0, u0_r[l]} >= vc_r)
          bad_l = 1'b1;
      end
    end
    full = ((CNT_W + 1)'(vc_r) + (CNT_W + 1)'(1) + (CNT_W + 1)'(two_layer_r)
            > (CNT_W + 1)'(MAX_VERTS))
        || ((CNT_W + 1)'(fc_r) + (CNT_W + 1)'(2) + (CNT_W + 1)'({two_layer_r, 1'b0})
            > (CNT_W + 1)'(MAX_FACES));
  end

  // Sequencer: next state, memory controls and result values.
  always_comb begin
    state_nxt = state_r;   op_nxt = op_r;         lsel_nxt = lsel_r;
    k_nxt = k_r;           two_layer_nxt = two_layer_r;
    weight_nxt = weight_r; vc_nxt = vc_r;         fc_nxt = fc_r;
    req_nxt = req_r;       idx_nxt = idx_r;       corner_nxt = corner_r;
    coord_nxt = coord_r;   vid_nxt = vid_r;       nbr_nxt = nbr_r;
    ncorn_nxt = ncorn_r;   pj_nxt = pj_r;         kappa_nxt = kappa_r;
    fb_nxt = fb_r;         f02_nxt = f02_r;       f12_nxt = f12_r;
    c02_nxt = c02_r;       c12_nxt = c12_r;       u0_nxt = u0_r;
    u1_nxt = u1_r;         e1_nxt = e1_r;         va_nxt = va_r;
    vb_nxt = vb_r;         nv_nxt = nv_r;         prod_nxt = prod_r;

    ov_nxt = 1'b0;         ostat_nxt = STAT_OK;   onv_nxt = '0;
    onf_nxt = '0;          ocoord_nxt = '0;       ovid_nxt = '0;
    onbr_nxt = '0;         oncorn_nxt = '0;       opj_nxt = '0;
    okap_nxt = '0;

    vram_we = 1'b0;  vram_waddr = idx_r;  vram_wdata = coord_r;  vram_raddr = idx_r;
    fram_we = 1'b0;  fram_waddr = idx_r;  fram_wdata = fram_rdata; fram_raddr = idx_r;
    fin = 1'b0;      fin_stat = STAT_OK;

    // Configuration beats are taken in any state.
    if (cfg_valid) begin
      if (cfg_index == CFG_TWO_LAYER) begin
        two_layer_nxt = cfg_data[0];
      end else begin
        weight_nxt = cfg_data;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt    = in_req_type;
          idx_nxt    = in_item_index;
          corner_nxt = in_corner;
          coord_nxt  = {in_coord_z, in_coord_y, in_coord_x};
          vid_nxt    = in_vertex_id;
          nbr_nxt    = in_neighbor_face;
          ncorn_nxt  = in_neighbor_corner;
          pj_nxt     = in_pj_value;
          kappa_nxt  = in_kappa_value;
          lsel_nxt   = 1'b0;
          case (in_req_type)
            REQ_WR_VERT: state_nxt = ST_VWR;
            REQ_RD_VERT: state_nxt = ST_VRD;
            REQ_WR_CORNER, REQ_RD_CORNER:
              state_nxt = (in_corner == CORNER_BAD) ? ST_FAIL : ST_FRD;
            REQ_SPLIT:   state_nxt = SP_CHK0;
            default:     state_nxt = ST_FAIL;
          endcase
        end
      end

      ST_FAIL: begin
        fin = 1'b1;
        fin_stat = STAT_RANGE;
      end

      // Vertex write and read.
      ST_VWR: begin
        vram_we = 1'b1;
        if (vc_r < CNT_W'(idx_r) + CNT_W'(1)) vc_nxt = CNT_W'(idx_r) + CNT_W'(1);
        fin = 1'b1;
      end
      ST_VRD: begin
        state_nxt = ST_VOUT;
      end
      ST_VOUT: begin
        ocoord_nxt = vram_rdata;
        fin = 1'b1;
      end

      // Face corner write (read-modify-write) and read.
      ST_FRD: begin
        state_nxt = (req_r == REQ_WR_CORNER) ? ST_FWR : ST_FOUT;
      end
      ST_FWR: begin
        fram_we = 1'b1;
        fram_wdata.verts[corner_r] = vid_r;
        fram_wdata.nbrs[corner_r]  = nbr_r;
        fram_wdata.ncorn[corner_r] = ncorn_r;
        fram_wdata.pj[corner_r]    = pj_r;
        fram_wdata.kappa[corner_r] = kappa_r;
        if (fc_r < CNT_W'(idx_r) + CNT_W'(1)) fc_nxt = CNT_W'(idx_r) + CNT_W'(1);
        fin = 1'b1;
      end
      ST_FOUT: begin
        ovid_nxt   = fram_rdata.verts[corner_r];
        onbr_nxt   = fram_rdata.nbrs[corner_r];
        oncorn_nxt = fram_rdata.ncorn[corner_r];
        opj_nxt    = fram_rdata.pj[corner_r];
        okap_nxt   = fram_rdata.kappa[corner_r];
        fin = 1'b1;
      end

      // Split: range checks, then read the split faces.
      SP_CHK0: begin
        if (corner_r == CORNER_BAD || {1'b0, idx_r} >= fc_r
            || (two_layer_r && {1'b0, idx_r ^ FIDX_W'(1)} >= fc_r)) begin
          fin = 1'b1;
          fin_stat = STAT_RANGE;
        end else begin
          fram_raddr = fa_l;
          state_nxt = SP_RDA;
        end
      end
      SP_RDA: begin
        fb_nxt[lsel_r]  = fram_rdata.nbrs[corner_r];
        f02_nxt[lsel_r] = fram_rdata.nbrs[e02];
        c02_nxt[lsel_r] = fram_rdata.ncorn[e02];
        u1_nxt[lsel_r]  = fram_rdata.verts[e01];
        if (!lsel_r) e1_nxt = fram_rdata.ncorn[corner_r];
        if (!last_l) begin
          lsel_nxt = 1'b1;
          fram_raddr = idx_r ^ FIDX_W'(1);
        end else begin
          lsel_nxt = 1'b0;
          state_nxt = SP_CHK1;
        end
      end
      SP_CHK1: begin
        if (fb_r[0] == NBR_NONE || (two_layer_r && fb_r[1] == NBR_NONE)) begin
          fin = 1'b1;
          fin_stat = STAT_BOUNDARY;
        end else if (!face_ok(fb_r[0], fc_r) || (two_layer_r && !face_ok(fb_r[1], fc_r))
                     || e1_r == CORNER_BAD) begin
          fin = 1'b1;
          fin_stat = STAT_RANGE;
        end else begin
          fram_raddr = fb_l;
          state_nxt = SP_RDB;
        end
      end
      SP_RDB: begin
        f12_nxt[lsel_r] = fram_rdata.nbrs[e12];
        c12_nxt[lsel_r] = fram_rdata.ncorn[e12];
        u0_nxt[lsel_r]  = fram_rdata.verts[e11];
        if (!last_l) begin
          lsel_nxt = 1'b1;
          fram_raddr = fb_r[1][FIDX_W-1:0];
        end else begin
          lsel_nxt = 1'b0;
          state_nxt = SP_CHK2;
        end
      end
      SP_CHK2: begin
        if (bad_l) begin
          fin = 1'b1;
          fin_stat = STAT_RANGE;
        end else if (full) begin
          fin = 1'b1;
          fin_stat = STAT_FULL;
        end else begin
          state_nxt = SP_VRA;
        end
      end

      // New vertex: fetch both endpoints and interpolate one axis at a time.
      SP_VRA: begin
        vram_raddr = u0_r[lsel_r];
        state_nxt = SP_VRB;
      end
      SP_VRB: begin
        va_nxt = vram_rdata;
        vram_raddr = u1_r[lsel_r];
        state_nxt = SP_VRC;
      end
      SP_VRC: begin
        vb_nxt = vram_rdata;
        k_nxt = 2'd0;
        state_nxt = SP_MUL;
      end
      SP_MUL: begin
        prod_nxt = $signed({1'b0, w_cl}) * diff;
        state_nxt = SP_ADD;
      end
      SP_ADD: begin
        nv_nxt[k_r] = sum[COORD_W+15:16];
        if (k_r == 2'd2) begin
          state_nxt = SP_VWR;
        end else begin
          k_nxt = k_r + 2'd1;
          state_nxt = SP_MUL;
        end
      end
      SP_VWR: begin
        vram_we = 1'b1;
        vram_waddr = ux_l;
        vram_wdata = nv_r;
        if (!last_l) begin
          lsel_nxt = 1'b1;
          state_nxt = SP_VRA;
        end else begin
          lsel_nxt = 1'b0;
          op_nxt = OP_P12;
          state_nxt = SP_FRD;
        end
      end

      // Face table updates: one row read per step, then a row write unless skipped.
      SP_FRD: begin
        fram_raddr = op_addr;
        if (skip_op) begin
          if (!last_l) begin
            lsel_nxt = 1'b1;
          end else begin
            lsel_nxt = 1'b0;
            op_nxt = fop_t'(op_r + 3'd1);
          end
        end else begin
          state_nxt = SP_FWR;
        end
      end
      SP_FWR: begin
        fram_we = 1'b1;
        fram_waddr = op_waddr;
        case (op_r)
          OP_P12: fram_wdata.nbrs[c12_r[lsel_r]] = {1'b0, fx1_l};
          OP_P02: fram_wdata.nbrs[c02_r[lsel_r]] = {1'b0, fx0_l};
          OP_CPA: begin
            fram_wdata.verts[e01] = ux_l;
            fram_wdata.nbrs[e01]  = {1'b0, fa_l};
            fram_wdata.ncorn[e01] = e02;
            fram_wdata.pj[e01]    = '0;
            fram_wdata.kappa[e01] = '0;
          end
          OP_CPB: begin
            fram_wdata.verts[e11] = ux_l;
            fram_wdata.nbrs[e11]  = {1'b0, fb_l};
            fram_wdata.ncorn[e11] = e12;
            fram_wdata.pj[e11]    = '0;
            fram_wdata.kappa[e11] = '0;
          end
          OP_MDA: begin
            fram_wdata.verts[corner_r] = ux_l;
            fram_wdata.nbrs[e02]       = {1'b0, fx0_l};
            fram_wdata.nbrs[corner_r]  = {1'b0, fx1_l};
            fram_wdata.ncorn[e02]      = e01;
            fram_wdata.pj[e02]         = '0;
            fram_wdata.kappa[e02]      = '0;
          end
          OP_MDB: begin
            fram_wdata.verts[e1_r] = ux_l;
            fram_wdata.nbrs[e12]   = {1'b0, fx1_l};
            fram_wdata.nbrs[e1_r]  = {1'b0, fx0_l};
            fram_wdata.ncorn[e12]  = e11;
            fram_wdata.pj[e12]     = '0;
            fram_wdata.kappa[e12]  = '0;
          end
          default: ;
        endcase
        state_nxt = SP_FRD;
        if (!last_l) begin
          lsel_nxt = 1'b1;
        end else begin
          lsel_nxt = 1'b0;
          if (op_r == OP_MDB) begin
            fin = 1'b1;
            onv_nxt = vc_r[VIDX_W-1:0];
            onf_nxt = fc_r[FIDX_W-1:0];
            vc_nxt = vc_r + CNT_W'(1) + CNT_W'(two_layer_r);
            fc_nxt = fc_r + CNT_W'(2) + CNT_W'({two_layer_r, 1'b0});
          end else begin
            op_nxt = fop_t'(op_r + 3'd1);
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Completion: present the result beat and return to idle.
    if (fin) begin
      state_nxt = ST_IDLE;
      ov_nxt = 1'b1;
      ostat_nxt = fin_stat;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_P12;
      lsel_r      <= 1'b0;
      k_r         <= 2'd0;
      two_layer_r <= 1'b0;
      weight_r    <= WGT_RESET;
      vc_r        <= '0;
      fc_r        <= '0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      lsel_r      <= lsel_nxt;
      k_r         <= k_nxt;
      two_layer_r <= two_layer_nxt;
      weight_r    <= weight_nxt;
      vc_r        <= vc_nxt;
      fc_r        <= fc_nxt;
      ov_r        <= ov_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;    idx_r   <= idx_nxt;   corner_r <= corner_nxt;
    coord_r  <= coord_nxt;  vid_r   <= vid_nxt;   nbr_r    <= nbr_nxt;
    ncorn_r  <= ncorn_nxt;  pj_r    <= pj_nxt;    kappa_r  <= kappa_nxt;
    fb_r     <= fb_nxt;     f02_r   <= f02_nxt;   f12_r    <= f12_nxt;
    c02_r    <= c02_nxt;    c12_r   <= c12_nxt;   u0_r     <= u0_nxt;
    u1_r     <= u1_nxt;     e1_r    <= e1_nxt;    va_r     <= va_nxt;
    vb_r     <= vb_nxt;     nv_r    <= nv_nxt;    prod_r   <= prod_nxt;
    ostat_r  <= ostat_nxt;  onv_r   <= onv_nxt;   onf_r    <= onf_nxt;
    ocoord_r <= ocoord_nxt; ovid_r  <= ovid_nxt;  onbr_r   <= onbr_nxt;
    oncorn_r <= oncorn_nxt; opj_r   <= opj_nxt;   okap_r   <= okap_nxt;
  end

  // Port drive.
  assign busy                = (state_r != ST_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = ov_r;
  assign out_status          = ostat_r;
  assign out_new_vertex      = onv_r;
  assign out_new_face        = onf_r;
  assign out_x               = ocoord_r[0];
  assign out_y               = ocoord_r[1];
  assign out_z               = ocoord_r[2];
  assign out_vertex_id       = ovid_r;
  assign out_neighbor_face   = onbr_r;
  assign out_neighbor_corner = oncorn_r;
  assign out_pj              = opj_r;
  assign out_kappa           = okap_r;

  // Checks on the sequencer.
  `TMES_ASSERT_IMP(a_result_idle, clk, rst_n, out_valid, !busy)
  `TMES_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `TMES_ASSERT_IMP(a_counts_grow, clk, rst_n, $past(rst_n), (vc_r >= $past(vc_r)) && (fc_r >= $past(fc_r)))

endmodule

@@ sv/tmes_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tmes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
